>>> design/icmp_echo_reply_rtt_stats_core_defines.svh
// Assertion macros shared by the ICMP echo reply RTT statistics block
`ifndef ICMP_ECHO_REPLY_RTT_STATS_CORE_DEFINES_SVH
`define ICMP_ECHO_REPLY_RTT_STATS_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define IERRS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ierrs assertion failed");
`define IERRS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ierrs assertion failed");
`else
`define IERRS_ASSERT_IMP(label, clk, rst, ante, cons)
`define IERRS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/ierrs_pkg.sv
// Types and constants of the ICMP echo reply RTT statistics block
package ierrs_pkg;

   localparam logic [1:0] STATUS_COUNTED    = 2'd0;
   localparam logic [1:0] STATUS_IGNORED    = 2'd1;
   localparam logic [1:0] STATUS_ICMP_SHORT = 2'd2;
   localparam logic [1:0] STATUS_ECHO_SHORT = 2'd3;

   localparam logic [7:0]  ICMP_ECHO_REPLY = 8'd0;
   localparam logic [15:0] ICMP_MIN_LEN    = 16'd8;
   localparam logic [15:0] ECHO_MIN_LEN    = 16'd16;
   localparam int          HDR_WORD_SHIFT  = 2;

   // second deltas above this always saturate, below minus one always clamp to zero
   localparam logic [31:0] DS_SAT_HI = 32'd4296;
   localparam int          DS_W      = 14;
   localparam int          DU_W      = 21;
   localparam int          PROD_W    = 35;
   localparam int          RTT_SUM_W = 36;
   localparam logic signed [PROD_W-1:0] USEC_PER_SEC = 35'sd1000000;

   // x / 1000 == (x * MS_RECIP) >> MS_SHIFT for every 32-bit x
   localparam logic [28:0] MS_RECIP   = 29'd274877907;
   localparam int          MS_SHIFT   = 38;
   localparam int          MS_PROD_W  = 61;

   localparam logic [31:0] MIN_RESET   = 32'd10000;
   localparam logic [31:0] ALL32       = 32'hFFFF_FFFF;
   localparam int          DIV_STEPS   = 32;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef struct packed {
      logic [3:0]  ip_header_words;
      logic [15:0] packet_length;
      logic [7:0]  icmp_kind;
      logic [15:0] icmp_identifier;
      logic [15:0] icmp_sequence;
      logic [7:0]  ip_ttl;
      logic [31:0] send_seconds;
      logic [19:0] send_microseconds;
      logic [31:0] recv_seconds;
      logic [19:0] recv_microseconds;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] icmp_length;
      logic [15:0] sequence_out;
      logic [7:0]  ttl_out;
      logic [31:0] rtt_micro;
      logic [31:0] max_rtt_ms;
      logic [31:0] min_rtt_ms;
      logic [31:0] avg_rtt_ms;
      logic [31:0] reply_total;
      logic [31:0] received_total;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [1:0]            status;
      logic [15:0]           icmp_length;
      logic [15:0]           sequence_num;
      logic [7:0]            ttl;
      logic signed [DS_W-1:0] ds;
      logic                  sat_hi;
      logic                  sat_lo;
      logic signed [DU_W-1:0] du;
   } entry_type;

endpackage

>>> design/ierrs_front.sv
// Front stage: identifier register, packet classification and time deltas
module ierrs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [15:0]         csr_wdata,
   input  logic                req_valid,
   output logic                req_ready,
   input  ierrs_pkg::req_type  req_data,
   output logic                push_valid,
   input  logic                push_ready,
   output ierrs_pkg::entry_type push_entry
);

   logic [15:0]          own_id_ff;
   logic                 ent_valid_ff;
   ierrs_pkg::entry_type ent_ff;
   ierrs_pkg::entry_type ent_in;

   logic [5:0]  hdr_bytes;
   logic [16:0] ilen;
   logic        short_icmp;
   logic        short_echo;
   logic        foreign;
   logic [32:0] ds_full;

   always_comb begin
      hdr_bytes  = {req_data.ip_header_words, 2'b00};
      ilen       = {1'b0, req_data.packet_length} - {11'b0, hdr_bytes};
      short_icmp = ilen[16] || (ilen[15:0] < ierrs_pkg::ICMP_MIN_LEN);
      short_echo = ilen[15:0] < ierrs_pkg::ECHO_MIN_LEN;
      foreign    = (req_data.icmp_kind != ierrs_pkg::ICMP_ECHO_REPLY) ||
                   (req_data.icmp_identifier != own_id_ff);
      ds_full    = {1'b0, req_data.recv_seconds} - {1'b0, req_data.send_seconds};

      ent_in.icmp_length  = ilen[15:0];
      ent_in.sequence_num = req_data.icmp_sequence;
      ent_in.ttl          = req_data.ip_ttl;
      ent_in.ds           = ds_full[ierrs_pkg::DS_W-1:0];
      ent_in.sat_hi       = !ds_full[32] && (ds_full[31:0] > ierrs_pkg::DS_SAT_HI);
      ent_in.sat_lo       = ds_full[32] && (ds_full != {33{1'b1}});
      ent_in.du           = {1'b0, req_data.recv_microseconds} -
                            {1'b0, req_data.send_microseconds};
      if (short_icmp) begin
         ent_in.status = ierrs_pkg::STATUS_ICMP_SHORT;
      end else if (foreign) begin
         ent_in.status = ierrs_pkg::STATUS_IGNORED;
      end else if (short_echo) begin
         ent_in.status = ierrs_pkg::STATUS_ECHO_SHORT;
      end else begin
         ent_in.status = ierrs_pkg::STATUS_COUNTED;
      end
   end

   assign req_ready  = !ent_valid_ff || push_ready;
   assign push_valid = ent_valid_ff;
   assign push_entry = ent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff    <= '0;
         ent_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            own_id_ff <= csr_wdata;
         end
         if (req_ready) begin
            ent_valid_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         ent_ff <= ent_in;
      end
   end

endmodule

>>> design/ierrs_queue.sv
// Small FIFO of classified items between front and back
module ierrs_queue #(
   parameter int DEPTH = ierrs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  ierrs_pkg::entry_type push_entry,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output ierrs_pkg::entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ierrs_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;
   logic                 do_push;
   logic                 do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> design/ierrs_back.sv
// Back sequencer: RTT, millisecond conversion, statistics and average divider
module ierrs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  ierrs_pkg::entry_type pop_entry,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ierrs_pkg::rsp_type   rsp_data
);

   localparam int DIV_CNT_W = $clog2(ierrs_pkg::DIV_STEPS);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL  = 7'b0000010,
      ST_RTT  = 7'b0000100,
      ST_MS   = 7'b0001000,
      ST_UPD  = 7'b0010000,
      ST_DIV  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } back_state_type;

   back_state_type state_ff;
   back_state_type state_in;

   ierrs_pkg::entry_type                       item_ff;
   logic signed [ierrs_pkg::PROD_W-1:0]        prod_ff;
   logic [31:0]                                rtt_ff;
   logic [31:0]                                ms_ff;
   logic [31:0]                                max_ff;
   logic [31:0]                                min_ff;
   logic [31:0]                                total_ff;
   logic [31:0]                                replies_ff;
   logic [31:0]                                avg_ff;
   logic [31:0]                                packets_ff;
   logic [31:0]                                quot_ff;
   logic [31:0]                                rem_ff;
   logic [DIV_CNT_W-1:0]                       div_cnt_ff;

   logic signed [ierrs_pkg::PROD_W-1:0]        prod_in;
   logic signed [ierrs_pkg::RTT_SUM_W-1:0]     rtt_sum;
   logic [31:0]                                rtt_in;
   logic [ierrs_pkg::MS_PROD_W-1:0]            ms_prod;
   logic [31:0]                                ms_in;
   logic [32:0]                                total_sum;
   logic [31:0]                                total_in;
   logic [31:0]                                replies_in;
   logic [32:0]                                div_shift;
   logic [32:0]                                div_diff;
   logic                                       div_ge;
   logic [31:0]                                quot_in;
   logic                                       div_last;
   logic                                       counted;

   always_comb begin
      prod_in = $signed({{(ierrs_pkg::PROD_W - ierrs_pkg::DS_W){item_ff.ds[ierrs_pkg::DS_W-1]}},
                         item_ff.ds}) * ierrs_pkg::USEC_PER_SEC;
      rtt_sum = $signed({prod_ff[ierrs_pkg::PROD_W-1], prod_ff}) +
                $signed({{(ierrs_pkg::RTT_SUM_W - ierrs_pkg::DU_W){item_ff.du[ierrs_pkg::DU_W-1]}},
                         item_ff.du});
      if (item_ff.sat_hi) begin
         rtt_in = ierrs_pkg::ALL32;
      end else if (item_ff.sat_lo || rtt_sum[ierrs_pkg::RTT_SUM_W-1]) begin
         rtt_in = '0;
      end else if (rtt_sum[ierrs_pkg::RTT_SUM_W-2:32] != '0) begin
         rtt_in = ierrs_pkg::ALL32;
      end else begin
         rtt_in = rtt_sum[31:0];
      end

      ms_prod = {29'b0, rtt_ff} * {32'b0, ierrs_pkg::MS_RECIP};
      ms_in   = 32'(ms_prod[ierrs_pkg::MS_PROD_W-1:ierrs_pkg::MS_SHIFT]);

      total_sum  = {1'b0, total_ff} + {1'b0, ms_ff};
      total_in   = total_sum[32] ? ierrs_pkg::ALL32 : total_sum[31:0];
      replies_in = (replies_ff == ierrs_pkg::ALL32) ? replies_ff : replies_ff + 32'd1;

      div_shift = {rem_ff, quot_ff[31]};
      div_diff  = div_shift - {1'b0, replies_ff};
      div_ge    = div_shift >= {1'b0, replies_ff};
      quot_in   = {quot_ff[30:0], div_ge};
      div_last  = div_cnt_ff == DIV_CNT_W'(ierrs_pkg::DIV_STEPS - 1);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               state_in = (pop_entry.status == ierrs_pkg::STATUS_COUNTED) ? ST_MUL : ST_OUT;
            end
         end
         ST_MUL: state_in = ST_RTT;
         ST_RTT: state_in = ST_MS;
         ST_MS:  state_in = ST_UPD;
         ST_UPD: state_in = ST_DIV;
         ST_DIV: begin
            if (div_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         max_ff     <= '0;
         min_ff     <= ierrs_pkg::MIN_RESET;
         total_ff   <= '0;
         replies_ff <= '0;
         avg_ff     <= '0;
         packets_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE && pop_valid) begin
            packets_ff <= packets_ff + 32'd1;
         end
         if (state_ff == ST_UPD) begin
            if (ms_ff > max_ff) begin
               max_ff <= ms_ff;
            end
            if (ms_ff < min_ff) begin
               min_ff <= ms_ff;
            end
            total_ff   <= total_in;
            replies_ff <= replies_in;
         end
         if (state_ff == ST_DIV && div_last) begin
            avg_ff <= quot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && pop_valid) begin
         item_ff <= pop_entry;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= prod_in;
      end
      if (state_ff == ST_RTT) begin
         rtt_ff <= rtt_in;
      end
      if (state_ff == ST_MS) begin
         ms_ff <= ms_in;
      end
      if (state_ff == ST_UPD) begin
         quot_ff    <= total_in;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (state_ff == ST_DIV) begin
         quot_ff    <= quot_in;
         rem_ff     <= div_ge ? div_diff[31:0] : div_shift[31:0];
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   assign pop_ready = state_ff == ST_IDLE;
   assign rsp_valid = state_ff == ST_OUT;
   assign counted   = item_ff.status == ierrs_pkg::STATUS_COUNTED;

   always_comb begin
      rsp_data.status         = item_ff.status;
      rsp_data.icmp_length    = item_ff.icmp_length;
      rsp_data.sequence_out   = counted ? item_ff.sequence_num : '0;
      rsp_data.ttl_out        = counted ? item_ff.ttl : '0;
      rsp_data.rtt_micro      = counted ? rtt_ff : '0;
      rsp_data.max_rtt_ms     = max_ff;
      rsp_data.min_rtt_ms     = min_ff;
      rsp_data.avg_rtt_ms     = avg_ff;
      rsp_data.reply_total    = replies_ff;
      rsp_data.received_total = packets_ff;
   end

endmodule

>>> design/icmp_echo_reply_rtt_stats_core.sv
// Top level of the ICMP echo reply RTT statistics block
// Takes the header fields and timestamps of one received ICMP packet per item and returns one
// result item with its status, ICMP length, RTT in microseconds and the running maximum,
// minimum, average, reply count and packet count. A front stage classifies each packet and
// forms the timestamp deltas, a small queue decouples it from the back sequencer, and the
// back does the arithmetic. A counted echo reply is picked up, its seconds delta multiplied,
// its RTT clamped and divided by 1000, the statistics updated, the bit-serial average divider
// run and the result delivered; other packets go from pick-up straight to delivery. The
// average divider sets the throughput for counted replies. The user must write the identifier
// register through csr_we and csr_wdata only while no item is in flight; nothing enforces it.
`include "icmp_echo_reply_rtt_stats_core_defines.svh"

module icmp_echo_reply_rtt_stats_core #(
   parameter int QUEUE_DEPTH = ierrs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  ierrs_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ierrs_pkg::rsp_type rsp_data
);

   logic                 push_valid;
   logic                 push_ready;
   ierrs_pkg::entry_type push_entry;
   logic                 pop_valid;
   logic                 pop_ready;
   ierrs_pkg::entry_type pop_entry;
   logic                 rsp_counted;

   ierrs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   ierrs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   ierrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_counted = rsp_valid && (rsp_data.status == ierrs_pkg::STATUS_COUNTED);

   `IERRS_ASSERT_IMP(a_counted_has_reply, clock, reset, rsp_counted, rsp_data.reply_total != '0)
   `IERRS_ASSERT_IMP(a_counted_min_le_max, clock, reset, rsp_counted, rsp_data.min_rtt_ms <= rsp_data.max_rtt_ms)
   `IERRS_ASSERT_IMP(a_counted_avg_le_max, clock, reset, rsp_counted, rsp_data.avg_rtt_ms <= rsp_data.max_rtt_ms)
   `IERRS_ASSERT_NXT(a_pop_holds_back, clock, reset, pop_valid && pop_ready, !pop_ready)

endmodule
